### hdl/pcqd_pkg.sv
// ----------------------------------------------------------------------------
// pcqd_pkg
// Shared constants, codes and types of the priority command queue with
// duplicate removal.
// ----------------------------------------------------------------------------
package pcqd_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    // width used to compare a request index against the entry count
    localparam int CMP_W       = 8;

    // request codes
    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_POP  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_RANGE = 2'd3;

    // command id that never takes part in duplicate removal
    localparam logic [7:0] EXEMPT_ID = 8'hFF;

    // one queue entry
    typedef struct packed {
        logic [7:0]  cmd;
        logic [1:0]  prio;
        logic [31:0] param_a;
        logic [31:0] param_b;
        logic [31:0] param_c;
    } t_entry;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic exec;
        logic dedup;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic push_ok;
    } t_dp_stat;

endpackage

### hdl/pcqd_req_if.sv
// ----------------------------------------------------------------------------
// pcqd_req_if
// Request channel: valid/ready handshake with the request word.
// ----------------------------------------------------------------------------
interface pcqd_req_if;

    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [3:0]  queue_index;
    logic [7:0]  command_id;
    logic [1:0]  priority_req;
    logic [31:0] param_a;
    logic [31:0] param_b;
    logic [31:0] param_c;

    modport source (
        output valid, req_type, queue_index, command_id, priority_req,
               param_a, param_b, param_c,
        input  ready
    );

    modport sink (
        input  valid, req_type, queue_index, command_id, priority_req,
               param_a, param_b, param_c,
        output ready
    );

endinterface

### hdl/pcqd_rsp_if.sv
// ----------------------------------------------------------------------------
// pcqd_rsp_if
// Response channel: valid/ready handshake with the response word.
// ----------------------------------------------------------------------------
interface pcqd_rsp_if;

    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [4:0]  entry_count;
    logic        queue_empty;
    logic [7:0]  read_command;
    logic [1:0]  read_priority;
    logic [31:0] read_param_a;
    logic [31:0] read_param_b;
    logic [31:0] read_param_c;

    modport source (
        output valid, status, entry_count, queue_empty, read_command,
               read_priority, read_param_a, read_param_b, read_param_c,
        input  ready
    );

    modport sink (
        input  valid, status, entry_count, queue_empty, read_command,
               read_priority, read_param_a, read_param_b, read_param_c,
        output ready
    );

endinterface

### hdl/pcqd_ctrl.sv
// ----------------------------------------------------------------------------
// pcqd_ctrl
// Sequencer of the queue: takes one request word, steps the datapath through
// execute and duplicate removal, and hands the result to the response register.
// ----------------------------------------------------------------------------
module pcqd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  pcqd_pkg::t_dp_stat i_stat,
    output pcqd_pkg::t_dp_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_DEDUP = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    // commands decoded from the state
    assign o_in_ready       = (r_state == ST_IDLE);
    assign o_cmd.capture    = i_in_valid && o_in_ready;
    assign o_cmd.exec       = (r_state == ST_EXEC);
    assign o_cmd.dedup      = (r_state == ST_DEDUP);
    assign o_cmd.load_out   = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
    assign o_out_valid      = r_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.capture) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = i_stat.push_ok ? ST_DEDUP : ST_DONE;
            end
            ST_DEDUP: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (o_cmd.load_out) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // response valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### hdl/pcqd_datapath.sv
// ----------------------------------------------------------------------------
// pcqd_datapath
// Entry row of the queue with per-entry shift paths for insert and removal,
// priority and duplicate search, request and response registers.
// ----------------------------------------------------------------------------
module pcqd_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_req_type,
    input  logic [3:0]         i_queue_index,
    input  logic [7:0]         i_command_id,
    input  logic [1:0]         i_priority_req,
    input  logic [31:0]        i_param_a,
    input  logic [31:0]        i_param_b,
    input  logic [31:0]        i_param_c,
    input  pcqd_pkg::t_dp_cmd  i_cmd,
    output pcqd_pkg::t_dp_stat o_stat,
    output logic [1:0]         o_status,
    output logic [4:0]         o_entry_count,
    output logic               o_queue_empty,
    output logic [7:0]         o_read_command,
    output logic [1:0]         o_read_priority,
    output logic [31:0]        o_read_param_a,
    output logic [31:0]        o_read_param_b,
    output logic [31:0]        o_read_param_c
);

    localparam int DEPTH = pcqd_pkg::QUEUE_DEPTH;
    localparam int CNT_W = pcqd_pkg::CNT_W;
    localparam int IDX_W = pcqd_pkg::IDX_W;
    localparam int CMP_W = pcqd_pkg::CMP_W;

    // request word
    logic [1:0]       r_req_type;
    logic [3:0]       r_idx;
    pcqd_pkg::t_entry r_new;

    // queue state
    pcqd_pkg::t_entry r_entry [DEPTH];
    pcqd_pkg::t_entry n_entry [DEPTH];
    pcqd_pkg::t_entry w_prev  [DEPTH];
    pcqd_pkg::t_entry w_next  [DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_pos;

    // result of the execute step
    logic [1:0]       r_status;
    logic [1:0]       n_status;
    pcqd_pkg::t_entry r_rd;
    pcqd_pkg::t_entry n_rd;

    // response register
    logic [1:0]       r_out_status;
    logic [4:0]       r_out_count;
    logic             r_out_empty;
    pcqd_pkg::t_entry r_out_rd;

    logic             w_full;
    logic             w_idx_ok;
    logic             w_push_ok;
    logic [CNT_W-1:0] w_ins_pos;
    logic             w_dup_hit;
    logic [CNT_W-1:0] w_dup_pos;
    logic             w_rm_en;
    logic [CNT_W-1:0] w_rm_at;

    // neighbor taps of each entry for the shift paths
    for (genvar g = 0; g < DEPTH; g++) begin : g_nbr
        if (g == 0) begin : g_head
            assign w_prev[g] = r_entry[g];
        end else begin : g_body
            assign w_prev[g] = r_entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_next[g] = r_entry[g];
        end else begin : g_inner
            assign w_next[g] = r_entry[g+1];
        end
    end

    // request checks
    assign w_full    = (r_count == CNT_W'(DEPTH));
    assign w_idx_ok  = (CMP_W'(r_idx) < CMP_W'(r_count));
    assign w_push_ok = (r_req_type == pcqd_pkg::REQ_PUSH) && !w_full;
    assign o_stat.push_ok = w_push_ok;

    // insert position: first valid entry of strictly lower priority
    always_comb begin
        w_ins_pos = r_count;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < r_count) && (r_entry[i].prio < r_new.prio)) begin
                w_ins_pos = CNT_W'(i);
            end
        end
    end

    // first other valid entry with the same command id
    always_comb begin
        w_dup_hit = 1'b0;
        w_dup_pos = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < r_count) && (CNT_W'(i) != r_pos) &&
                (r_entry[i].cmd == r_new.cmd)) begin
                w_dup_hit = 1'b1;
                w_dup_pos = CNT_W'(i);
            end
        end
    end

    // removal: pop at the index, or the entry nearer the head of a duplicate pair
    always_comb begin
        w_rm_en = 1'b0;
        w_rm_at = CNT_W'(r_idx);
        if (i_cmd.exec && (r_req_type == pcqd_pkg::REQ_POP) &&
            (r_count != '0) && w_idx_ok) begin
            w_rm_en = 1'b1;
        end else if (i_cmd.dedup && (r_new.cmd != pcqd_pkg::EXEMPT_ID) && w_dup_hit) begin
            w_rm_en = 1'b1;
            w_rm_at = (w_dup_pos < r_pos) ? w_dup_pos : r_pos;
        end
    end

    // entry row next state
    always_comb begin
        n_entry = r_entry;
        n_count = r_count;
        if (i_cmd.exec && w_push_ok) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (CNT_W'(i) == w_ins_pos) begin
                    n_entry[i] = r_new;
                end else if ((CNT_W'(i) > w_ins_pos) && (CNT_W'(i) <= r_count)) begin
                    n_entry[i] = w_prev[i];
                end
            end
            n_count = r_count + CNT_W'(1);
        end else if (w_rm_en) begin
            for (int i = 0; i < DEPTH; i++) begin
                if ((CNT_W'(i) >= w_rm_at) && (CNT_W'(i + 1) < r_count)) begin
                    n_entry[i] = w_next[i];
                end
            end
            n_count = r_count - CNT_W'(1);
        end
    end

    // status and read fields of the execute step
    always_comb begin
        n_status = pcqd_pkg::STAT_OK;
        n_rd     = '0;
        unique case (r_req_type)
            pcqd_pkg::REQ_PUSH: begin
                if (w_full) n_status = pcqd_pkg::STAT_FULL;
            end
            pcqd_pkg::REQ_POP: begin
                if (r_count == '0) begin
                    n_status = pcqd_pkg::STAT_EMPTY;
                end else if (!w_idx_ok) begin
                    n_status = pcqd_pkg::STAT_RANGE;
                end
            end
            pcqd_pkg::REQ_READ: begin
                if (!w_idx_ok) begin
                    n_status = pcqd_pkg::STAT_RANGE;
                end else begin
                    n_rd = r_entry[IDX_W'(r_idx)];
                end
            end
            default: begin
                n_status = pcqd_pkg::STAT_OK;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_cmd.capture) begin
            r_req_type    <= i_req_type;
            r_idx         <= i_queue_index;
            r_new.cmd     <= i_command_id;
            r_new.prio    <= i_priority_req;
            r_new.param_a <= i_param_a;
            r_new.param_b <= i_param_b;
            r_new.param_c <= i_param_c;
        end
        if (i_cmd.exec) begin
            r_pos    <= w_ins_pos;
            r_status <= n_status;
            r_rd     <= n_rd;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_count  <= 5'(r_count);
            r_out_empty  <= (r_count == '0);
            r_out_rd     <= r_rd;
        end
    end

    assign o_status        = r_out_status;
    assign o_entry_count   = r_out_count;
    assign o_queue_empty   = r_out_empty;
    assign o_read_command  = r_out_rd.cmd;
    assign o_read_priority = r_out_rd.prio;
    assign o_read_param_a  = r_out_rd.param_a;
    assign o_read_param_b  = r_out_rd.param_b;
    assign o_read_param_c  = r_out_rd.param_c;

endmodule

### hdl/priority_command_queue_dedup_core.sv
// ----------------------------------------------------------------------------
// priority_command_queue_dedup_core
// Sorted command queue with push, pop-at-index, read-at-index and removal of
// duplicate command ids.
// ----------------------------------------------------------------------------
// Usage:
//   i_req is a valid/ready request channel. Each word is a push (command id,
//   priority, three parameters), a pop at queue_index or a read at
//   queue_index. Higher priority entries sit nearer the head (index 0).
//   o_rsp returns exactly one response word per request: status, entry count
//   after the request, empty flag and the read entry (zero unless a read
//   succeeded).
//   A push that finds room passes through an extra duplicate search step over
//   the updated entry row before its response; pop, read and a push to a full
//   queue skip that step. One request is in flight at a time, so the block
//   takes no new request until the last one has reached the response register.
//   The response sits in an output register, so the next request is taken
//   while a response waits; if the receiver stalls, the block holds the next
//   finished result and stops taking requests until the register drains.
//   Reset (synchronous, active low) empties the queue and drops any pending
//   response; entry contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module priority_command_queue_dedup_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcqd_req_if.sink    i_req,
    pcqd_rsp_if.source  o_rsp
);

    pcqd_pkg::t_dp_cmd  w_cmd;
    pcqd_pkg::t_dp_stat w_stat;

    // sequencer
    pcqd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // entry row and response register
    pcqd_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_type      (i_req.req_type),
        .i_queue_index   (i_req.queue_index),
        .i_command_id    (i_req.command_id),
        .i_priority_req  (i_req.priority_req),
        .i_param_a       (i_req.param_a),
        .i_param_b       (i_req.param_b),
        .i_param_c       (i_req.param_c),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_status        (o_rsp.status),
        .o_entry_count   (o_rsp.entry_count),
        .o_queue_empty   (o_rsp.queue_empty),
        .o_read_command  (o_rsp.read_command),
        .o_read_priority (o_rsp.read_priority),
        .o_read_param_a  (o_rsp.read_param_a),
        .o_read_param_b  (o_rsp.read_param_b),
        .o_read_param_c  (o_rsp.read_param_c)
    );

`ifndef SYNTHESIS
    // busy right after a request is taken
    a_busy_after_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.capture |=> !i_req.ready)
        else $error("request taken while previous one still executing");

    // a failed request returns no read data
    a_fail_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != pcqd_pkg::STAT_OK)) |->
        ((o_rsp.read_command == 8'd0) && (o_rsp.read_priority == 2'd0)))
        else $error("read data on failed request");

    // full status only with a full queue
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == pcqd_pkg::STAT_FULL)) |->
        (o_rsp.entry_count == 5'(pcqd_pkg::QUEUE_DEPTH)))
        else $error("full status with queue not full");

    // empty status only with an empty queue
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == pcqd_pkg::STAT_EMPTY)) |-> o_rsp.queue_empty)
        else $error("empty status with entries present");
`endif

endmodule
